// ===== hdl/ssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the span slot registry.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int unsigned BASE_W   = 64;
    localparam int unsigned LENGTH_W = 32;
    localparam int unsigned STRIDE_W = 16;
    localparam int unsigned HIN_W    = 10;
    localparam int unsigned HOUT_W   = 9;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned STATUS_W = 3;

    // Only pointer-sized elements are accepted.
    localparam logic [STRIDE_W-1:0] STRIDE_ACCEPTED = STRIDE_W'(8);
    localparam int unsigned         ALIGN_BITS      = 3;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_STRIDE = 3'd1,
        ST_NULL_BASE  = 3'd2,
        ST_PARTIAL    = 3'd3,
        ST_FULL       = 3'd4,
        ST_IGNORED    = 3'd5
    } t_status;

endpackage

// ===== hdl/ssr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_req_if / ssr_rsp_if
// Valid/ready channels carrying registry requests and results.
// ----------------------------------------------------------------------------
interface ssr_req_if
    import ssr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [BASE_W-1:0]   base_address;
    logic [LENGTH_W-1:0] byte_length;
    logic [STRIDE_W-1:0] element_stride;
    logic                is_conservative;
    logic [HIN_W-1:0]    slot_handle;

    modport source (
        output valid, op, base_address, byte_length, element_stride,
               is_conservative, slot_handle,
        input  ready
    );
    modport sink (
        input  valid, op, base_address, byte_length, element_stride,
               is_conservative, slot_handle,
        output ready
    );
endinterface

interface ssr_rsp_if
    import ssr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HOUT_W-1:0]   handle_out;
    logic [COUNT_W-1:0]  active_count;
    logic [COUNT_W-1:0]  conservative_count;

    modport source (
        output valid, status, handle_out, active_count, conservative_count,
        input  ready
    );
    modport sink (
        input  valid, status, handle_out, active_count, conservative_count,
        output ready
    );
endinterface

// ===== hdl/span_slot_registry_free_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// span_slot_registry_free_list
// Slot table for memory spans with a LIFO free list of released slots.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request item: op 0 adds a span (base, length, stride,
//   kind), op 1 removes the span held under slot_handle. o_rsp returns one
//   result item for every request: status, the handle of a new span, and
//   the live and conservative span counts after the request.
// Operation:
//   A request is accepted in idle and the slot entry is read from the slot
//   memory into a register at that edge; the decide step in S_EXEC then
//   writes the entry back and loads the result register. A new request is
//   taken only in idle, once the decide step of the last one is done.
// Reset:
//   Synchronous, active low. The free list is empty, no slot has ever been
//   handed out and both counts are zero. The slot memory needs no clearing:
//   only entries of slots below the bump pointer are ever used, and each was written
//   when it was first handed out.
// Backpressure:
//   The result register parts the two sides: a new request is taken while
//   an earlier result still waits, and the decide step holds until the
//   result register is free.
// ----------------------------------------------------------------------------
module span_slot_registry_free_list
    import ssr_pkg::*;
#(
    parameter int unsigned SLOTS = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssr_req_if.sink   i_req,
    ssr_rsp_if.source o_rsp
);

    // Index, count and compare widths.
    localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW   = $clog2(SLOTS + 1);
    localparam int unsigned HCW  = (CW > HIN_W) ? CW : HIN_W;
    localparam int unsigned HXW  = (IW > HOUT_W) ? IW : HOUT_W;
    localparam int unsigned CXW  = (CW > COUNT_W) ? CW : COUNT_W;

    // One memory word per slot: live bit, kind and free list link.
    typedef struct packed {
        logic          live;
        logic          kind;
        logic [IW-1:0] link;
    } t_slot_entry;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_slot_entry r_slot_mem [SLOTS];
    t_slot_entry r_rdata;

    t_state r_state, n_state;

    // Held request.
    logic                r_op;
    logic [BASE_W-1:0]   r_base;
    logic [LENGTH_W-1:0] r_length;
    logic [STRIDE_W-1:0] r_stride;
    logic                r_kind;
    logic [HCW-1:0]      r_handle;

    // Registry state.
    logic [IW-1:0] r_free_head, n_free_head;
    logic          r_free_empty, n_free_empty;
    logic [CW-1:0] r_bump, n_bump;
    logic [CW-1:0] r_live_cnt, n_live_cnt;
    logic [CW-1:0] r_cons_cnt, n_cons_cnt;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [HOUT_W-1:0]   r_hout, n_hout;
    logic [COUNT_W-1:0]  r_act, n_act;
    logic [COUNT_W-1:0]  r_cons, n_cons;

    logic          accept;
    logic [HCW-1:0] in_handle;
    logic [IW-1:0]  rd_addr;
    logic           out_free;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    t_slot_entry    mem_wdata;

    // Decide-step scratch.
    t_status       st;
    logic [IW-1:0] slot;
    logic [CW-1:0] free_size;
    logic [CW-1:0] live_after;
    logic [CW-1:0] cons_after;

    assign accept    = i_req.valid && i_req.ready;
    assign in_handle = HCW'(i_req.slot_handle);
    assign out_free  = !r_out_valid || o_rsp.ready;

    // Add reads the head of the free list for its link, remove reads its slot.
    assign rd_addr = (i_req.op == OP_REMOVE) ? in_handle[IW-1:0] : r_free_head;

    assign i_req.ready              = (r_state == S_IDLE);
    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.status             = r_status;
    assign o_rsp.handle_out         = r_hout;
    assign o_rsp.active_count       = r_act;
    assign o_rsp.conservative_count = r_cons;

    // Slot memory: one read port registered at accept, one write port.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_slot_mem[rd_addr];
        end
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Hold the request payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_req.op;
            r_base   <= i_req.base_address;
            r_length <= i_req.byte_length;
            r_stride <= i_req.element_stride;
            r_kind   <= i_req.is_conservative;
            r_handle <= in_handle;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_free_empty = r_free_empty;
        n_bump       = r_bump;
        n_live_cnt   = r_live_cnt;
        n_cons_cnt   = r_cons_cnt;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_status     = r_status;
        n_hout       = r_hout;
        n_act        = r_act;
        n_cons       = r_cons;
        mem_we       = 1'b0;
        mem_waddr    = r_handle[IW-1:0];
        mem_wdata    = r_rdata;
        st           = ST_OK;
        slot         = '0;
        free_size    = r_bump - r_live_cnt;
        live_after   = r_live_cnt;
        cons_after   = r_cons_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if (r_op == OP_ADD) begin
                        // Check order: stride, null base, partial length, capacity.
                        priority if (r_stride != STRIDE_ACCEPTED) begin
                            st = ST_BAD_STRIDE;
                        end else if (r_length != '0 && r_base == '0) begin
                            st = ST_NULL_BASE;
                        end else if (r_length[ALIGN_BITS-1:0] != '0) begin
                            st = ST_PARTIAL;
                        end else if (!r_free_empty) begin
                            // Pop the most recently freed slot.
                            slot = r_free_head;
                            if (free_size <= CW'(1)) begin
                                n_free_empty = 1'b1;
                            end else begin
                                n_free_head = r_rdata.link;
                            end
                        end else if (r_bump < CW'(SLOTS)) begin
                            // Take the next slot never used.
                            slot   = r_bump[IW-1:0];
                            n_bump = r_bump + CW'(1);
                        end else begin
                            st = ST_FULL;
                        end
                        if (st == ST_OK) begin
                            mem_we         = 1'b1;
                            mem_waddr      = slot;
                            mem_wdata.live = 1'b1;
                            mem_wdata.kind = r_kind;
                            mem_wdata.link = '0;
                            live_after     = r_live_cnt + CW'(1);
                            cons_after     = r_cons_cnt + CW'(r_kind);
                        end
                    end else begin
                        // Remove only a slot handed out and still live.
                        if (r_handle < HCW'(r_bump) && r_rdata.live) begin
                            mem_we         = 1'b1;
                            mem_waddr      = r_handle[IW-1:0];
                            mem_wdata.live = 1'b0;
                            mem_wdata.kind = 1'b0;
                            mem_wdata.link = r_free_empty ? '0 : r_free_head;
                            n_free_head    = r_handle[IW-1:0];
                            n_free_empty   = 1'b0;
                            live_after     = r_live_cnt - CW'(1);
                            cons_after     = r_cons_cnt - CW'(r_rdata.kind);
                        end else begin
                            st = ST_IGNORED;
                        end
                    end
                    n_live_cnt  = live_after;
                    n_cons_cnt  = cons_after;
                    n_out_valid = 1'b1;
                    n_status    = st;
                    n_hout      = (r_op == OP_ADD && st == ST_OK)
                                  ? HOUT_W'(HXW'(slot)) : '0;
                    n_act       = COUNT_W'(CXW'(live_after));
                    n_cons      = COUNT_W'(CXW'(cons_after));
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, registry registers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_free_empty <= 1'b1;
            r_bump       <= '0;
            r_live_cnt   <= '0;
            r_cons_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_free_empty <= n_free_empty;
            r_bump       <= n_bump;
            r_live_cnt   <= n_live_cnt;
            r_cons_cnt   <= n_cons_cnt;
            r_out_valid  <= n_out_valid;
        end
        r_status <= n_status;
        r_hout   <= n_hout;
        r_act    <= n_act;
        r_cons   <= n_cons;
    end

endmodule
